FILE: rtl/rfw_pkg.sv
// Shared types and constants for the ring FIFO with fill watermark.
// Used by the top level, the generic RAM's user and the port checker.
package rfw_pkg;

    // Configuration and field widths fixed by the interface
    localparam int CAP_CFG_W  = 11;
    localparam int WORD_W     = 32;
    localparam int USED_W     = 10;
    localparam int FREE_W     = 11;
    localparam int WM_W       = 10;

    // Default ring size, capacity after reset and minimum capacity
    localparam int MAX_SLOTS_DEF = 1024;
    localparam int CAP_RESET     = 1024;
    localparam int CAP_MIN       = 2;

    typedef enum logic [1:0] {
        FUNC_PUSH  = 2'd0,
        FUNC_POP   = 2'd1,
        FUNC_PEEK  = 2'd2,
        FUNC_LEVEL = 2'd3
    } t_func;

    typedef struct packed {
        t_func               func;
        logic [WORD_W-1:0]   push_word;
    } t_request;

    typedef struct packed {
        logic                status;
        logic [WORD_W-1:0]   read_word;
        logic [USED_W-1:0]   used_count;
        logic [FREE_W-1:0]   free_count;
        logic [WM_W-1:0]     high_watermark;
    } t_result;

endpackage

FILE: rtl/ring_fifo_with_watermark.sv
// Ring FIFO of 32-bit words with a fill high watermark.
// Depends on rfw_pkg and rfw_ram.
//
// Every request (push, pop, peek or level query) produces one result. The
// block takes one request per clock: pointers, full/empty checks and the
// watermark are all resolved in the cycle of acceptance, and the result is
// shown in the next cycle, when the ring store's registered read data for
// a pop or peek arrives. The result sits in an output stage; while it waits
// to be taken, o_stall holds off the next request, so the store read data
// stays put. The ring uses capacity slots (written through i_cfg_data,
// clamped to 2..MAX_SLOTS) and always keeps one slot empty, so it holds at
// most capacity-1 words. A capacity write clears both pointers and the
// watermark but keeps the stored words; write it only while no result is
// pending. There is no clearing pass: a slot is only read after a push.
module ring_fifo_with_watermark #(
    parameter int MAX_SLOTS = rfw_pkg::MAX_SLOTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration: capacity register
    input  logic                              i_cfg_we,
    input  logic [rfw_pkg::CAP_CFG_W-1:0]     i_cfg_data,
    // request channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  rfw_pkg::t_request                 i_req,
    // result channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output rfw_pkg::t_result                  o_rsp
);

    localparam int IdxW     = $clog2(MAX_SLOTS);
    localparam int CapW     = $clog2(MAX_SLOTS + 1);
    localparam int UsedW    = rfw_pkg::USED_W;
    localparam int FreeW    = rfw_pkg::FREE_W;
    localparam int WmW      = rfw_pkg::WM_W;
    localparam int ResetCap = (rfw_pkg::CAP_RESET > MAX_SLOTS) ? MAX_SLOTS
                                                               : rfw_pkg::CAP_RESET;

    // Architectural state
    logic [CapW-1:0] r_cap,  n_cap;
    logic [IdxW-1:0] r_widx, n_widx;
    logic [IdxW-1:0] r_ridx, n_ridx;
    logic [IdxW-1:0] r_peak, n_peak;

    // Output stage
    logic            r_out_valid, n_out_valid;
    logic            r_status,    n_status;
    logic            r_rd_ok,     n_rd_ok;

    logic                        accept;
    logic [CapW-1:0]             widx_inc, ridx_inc;
    logic [IdxW-1:0]             widx_adv, ridx_adv;
    logic                        full, empty;
    logic [CapW-1:0]             fill_now, fill_out, free_out;
    logic [CapW-1:0]             cfg_cap;
    logic                        ram_we, ram_re;
    logic [rfw_pkg::WORD_W-1:0]  ram_rdata;

    // Fill level from a pointer pair; the write pointer may have wrapped.
    function automatic logic [CapW-1:0] fill_of(input logic [IdxW-1:0] w,
                                                input logic [IdxW-1:0] r,
                                                input logic [CapW-1:0] cap);
        logic [CapW-1:0] f;
        if (w >= r) begin
            f = CapW'(w) - CapW'(r);
        end else begin
            f = CapW'(w) + cap - CapW'(r);
        end
        return f;
    endfunction

    // Take the next request only when the output stage is free or draining
    assign o_stall = r_out_valid & i_stall;
    assign accept  = i_valid & ~o_stall;

    // Pre-increment pointers, wrapping at the configured capacity
    always_comb begin
        widx_inc = CapW'(r_widx) + CapW'(1);
        ridx_inc = CapW'(r_ridx) + CapW'(1);
        widx_adv = (widx_inc >= r_cap) ? '0 : IdxW'(widx_inc);
        ridx_adv = (ridx_inc >= r_cap) ? '0 : IdxW'(ridx_inc);
        full     = (widx_adv == r_ridx);
        empty    = (r_ridx == r_widx);
        fill_now = fill_of(r_widx, r_ridx, r_cap);
    end

    // Clamp a capacity write into the supported range
    always_comb begin
        if (int'(i_cfg_data) < rfw_pkg::CAP_MIN) begin
            cfg_cap = CapW'(rfw_pkg::CAP_MIN);
        end else if (int'(i_cfg_data) > MAX_SLOTS) begin
            cfg_cap = CapW'(MAX_SLOTS);
        end else begin
            cfg_cap = CapW'(i_cfg_data);
        end
    end

    // Request decode: update pointers and watermark, launch store accesses
    always_comb begin
        n_cap       = r_cap;
        n_widx      = r_widx;
        n_ridx      = r_ridx;
        n_peak      = r_peak;
        n_status    = r_status;
        n_rd_ok     = r_rd_ok;
        n_out_valid = r_out_valid & i_stall;
        ram_we      = 1'b0;
        ram_re      = 1'b0;

        if (accept) begin
            n_out_valid = 1'b1;
            n_status    = 1'b0;
            n_rd_ok     = 1'b0;
            case (i_req.func)
                rfw_pkg::FUNC_PUSH: begin
                    if (full) begin
                        n_status = 1'b1;
                    end else begin
                        ram_we = 1'b1;
                        n_widx = widx_adv;
                    end
                end
                rfw_pkg::FUNC_POP: begin
                    if (empty) begin
                        n_status = 1'b1;
                    end else begin
                        ram_re  = 1'b1;
                        n_rd_ok = 1'b1;
                        n_ridx  = ridx_adv;
                    end
                end
                rfw_pkg::FUNC_PEEK: begin
                    if (empty) begin
                        n_status = 1'b1;
                    end else begin
                        ram_re  = 1'b1;
                        n_rd_ok = 1'b1;
                    end
                end
                rfw_pkg::FUNC_LEVEL: begin
                    if (IdxW'(fill_now) > r_peak) begin
                        n_peak = IdxW'(fill_now);
                    end
                end
                default: begin
                    n_status = 1'b0;
                end
            endcase
        end

        // Capacity write: clear pointers, watermark (user keeps block idle)
        if (i_cfg_we) begin
            n_cap  = cfg_cap;
            n_widx = '0;
            n_ridx = '0;
            n_peak = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CapW'(ResetCap);
            r_widx      <= '0;
            r_ridx      <= '0;
            r_peak      <= '0;
            r_out_valid <= 1'b0;
            r_status    <= 1'b0;
            r_rd_ok     <= 1'b0;
        end else begin
            r_cap       <= n_cap;
            r_widx      <= n_widx;
            r_ridx      <= n_ridx;
            r_peak      <= n_peak;
            r_out_valid <= n_out_valid;
            r_status    <= n_status;
            r_rd_ok     <= n_rd_ok;
        end
    end

    // Ring store: push writes at the advanced write pointer, pop/peek read
    // at the advanced read pointer
    rfw_ram #(
        .WIDTH (rfw_pkg::WORD_W),
        .DEPTH (MAX_SLOTS)
    ) u_ring_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (widx_adv),
        .i_wdata (i_req.push_word),
        .i_re    (ram_re),
        .i_raddr (ridx_adv),
        .o_rdata (ram_rdata)
    );

    // Counts come straight from the pointers, which hold until the result
    // is taken
    always_comb begin
        fill_out = fill_of(r_widx, r_ridx, r_cap);
        free_out = r_cap - fill_out;
    end

    assign o_valid              = r_out_valid;
    assign o_rsp.status         = r_status;
    assign o_rsp.read_word      = r_rd_ok ? ram_rdata : '0;
    assign o_rsp.used_count     = UsedW'(fill_out);
    assign o_rsp.free_count     = FreeW'(free_out);
    assign o_rsp.high_watermark = WmW'(r_peak);

endmodule

FILE: rtl/rfw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rfw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/rfw_checker.sv
// Port-level checker for the ring FIFO with watermark, bound to the top level.
// Depends on rfw_pkg.
module rfw_assertions (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rfw_pkg::CAP_CFG_W-1:0]  i_cfg_data,
    input  logic                           i_valid,
    input  logic                           o_stall,
    input  rfw_pkg::t_request              i_req,
    input  logic                           o_valid,
    input  logic                           i_stall,
    input  rfw_pkg::t_result               o_rsp
);

    localparam int SumW = rfw_pkg::FREE_W + 1;

    logic                     r_seen;
    logic [rfw_pkg::WM_W-1:0] r_last_wm;
    logic [SumW-1:0]          r_last_sum;
    logic [SumW-1:0]          sum_now;
    logic                     out_take;

    assign sum_now  = SumW'(o_rsp.used_count) + SumW'(o_rsp.free_count);
    assign out_take = o_valid & ~i_stall;

    // Remember the last delivered watermark and capacity since a clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_seen <= 1'b0;
        end else if (out_take) begin
            r_seen <= 1'b1;
        end
        if (out_take) begin
            r_last_wm  <= o_rsp.high_watermark;
            r_last_sum <= sum_now;
        end
    end

    // A refused request never returns data
    a_refuse_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.status |-> o_rsp.read_word == '0)
        else $error("refused result carries a data word");

    // Watermark only rises between clears
    a_wm_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_take && r_seen && !i_cfg_we |-> o_rsp.high_watermark >= r_last_wm)
        else $error("high watermark dropped without a clear");

    // used + free is the capacity, constant between capacity writes
    a_sum_const: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_take && r_seen && !i_cfg_we |-> sum_now == r_last_sum)
        else $error("used plus free changed without a capacity write");

    // A stalled result stays valid
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

endmodule

bind ring_fifo_with_watermark rfw_assertions u_rfw_assertions (.*);
